FILE: hdl/cartridge_bank_mapper_with_irq_top_assert.svh
// ----------------------------------------------------------------------------
// cartridge bank mapper assertion macros
// shorthand for the concurrent checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_TOP_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_TOP_ASSERT_SVH

// same-cycle implication, checked only out of reset
`define CBM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked only out of reset
`define CBM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// shared types and constants of the cartridge bank mapper
// ----------------------------------------------------------------------------
package cbm_pkg;

    // default depth of the command queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // request kinds on the input tuser
    typedef enum logic [1:0] {
        REQ_LOW  = 2'd0,
        REQ_ROM  = 2'd1,
        REQ_TICK = 2'd2,
        REQ_RSVD = 2'd3
    } cbm_req_t;

    // low register addresses
    localparam logic [15:0] ADDR_SCREEN  = 16'h42FE;
    localparam logic [15:0] ADDR_MIRROR  = 16'h42FF;
    localparam logic [15:0] ADDR_IRQ_OFF = 16'h4501;
    localparam logic [15:0] ADDR_CNT_LO  = 16'h4502;
    localparam logic [15:0] ADDR_CNT_HI  = 16'h4503;

    // nametable maps
    localparam logic [3:0] MAP_SINGLE0 = 4'd0;
    localparam logic [3:0] MAP_SINGLE1 = 4'd15;
    localparam logic [3:0] MAP_VERT    = 4'd10;
    localparam logic [3:0] MAP_HORIZ   = 4'd12;

    // irq counter
    localparam logic [16:0] TICK_STEP = 17'd133;
    localparam logic [16:0] CNT_LIMIT = 17'h0FFFF;

    // decoded commands handed from front to back
    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_MIRROR  = 3'd1,
        OP_IRQ_OFF = 3'd2,
        OP_CNT_LO  = 3'd3,
        OP_CNT_HI  = 3'd4,
        OP_ROM     = 3'd5,
        OP_TICK    = 3'd6
    } cbm_op_t;

    typedef struct packed {
        cbm_op_t    op;
        logic [7:0] arg;   // byte, or nametable map in the low nibble
    } cbm_cmd_t;

    // queue status seen by front, back and top
    typedef struct packed {
        logic full;
        logic empty;
    } cbm_qstat_t;

    // result transfer layout
    typedef struct packed {
        logic [3:0]  pad;
        logic [15:0] irq_count;
        logic        irq_armed;
        logic        irq_pulse;
        logic [3:0]  nt_map;
        logic [1:0]  chr_page;
        logic [3:0]  prg_page;
    } cbm_result_t;

endpackage

FILE: hdl/cartridge_bank_mapper_with_irq_top.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_top
// cartridge bank mapper with scanline irq counter, stream in and stream out
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                                         per transfer
//  s_axis    in    tuser request kind, tdata address and byte       one request
//  m_axis    out   tdata banks, nametable map, irq state            one result
//
//  one result per accepted request, in order; one request per cycle sustained
//  while m_axis_tready stays high; a request is registered in the queue, then
//  in the output register; the state update is a single 17-bit add and compare
//  aresetn (synchronous) clears the queue and sets prg 0, chr 0, vertical
//  mirroring, irq disarmed and counter 0
//  a stalled m_axis backs up into the queue; s_axis_tready drops only when
//  the queue is full
//
module cartridge_bank_mapper_with_irq_top
    import cbm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] addr, [23:16] data
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [3:0] prg page, [5:4] chr page, [9:6] nt_map,
                                        // [10] irq_pulse, [11] irq_armed,
                                        // [27:12] irq_count, [31:28] zero
);

`include "cartridge_bank_mapper_with_irq_top_assert.svh"

    cbm_qstat_t q_stat;
    cbm_cmd_t   push_cmd;
    cbm_cmd_t   pop_cmd;
    logic       push;
    logic       pop;

    // decode: address and request kind become a command
    cbm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_stat        (q_stat),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    // short fifo decouples decode from execute
    cbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    // execute: mapper state, irq counter and the result register
    cbm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (pop_cmd),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // result transfer split into fields for the checks below
    cbm_result_t out_view;
    logic        pulse_ok;
    logic        map_ok;

    assign out_view = m_axis_tdata;
    assign pulse_ok = (out_view.irq_count == 16'd0) && out_view.irq_armed;
    assign map_ok   = (out_view.nt_map == MAP_SINGLE0) || (out_view.nt_map == MAP_SINGLE1) ||
                      (out_view.nt_map == MAP_VERT) || (out_view.nt_map == MAP_HORIZ);

    // an overflowing tick always leaves the counter cleared and the irq armed
    `CBM_ASSERT_NOW(a_pulse_clears, aclk, aresetn, m_axis_tvalid && out_view.irq_pulse, pulse_ok, "irq pulse with nonzero count or disarmed")
    // the nametable map is one of the four mirroring modes
    `CBM_ASSERT_NOW(a_map_legal, aclk, aresetn, m_axis_tvalid, map_ok, "illegal nametable map")
    // queued work reaches the output with no bubble after a drain
    `CBM_ASSERT_NEXT(a_no_bubble, aclk, aresetn, m_axis_tvalid && m_axis_tready && !q_stat.empty, m_axis_tvalid, "output idle while commands are queued")

endmodule

FILE: hdl/cbm_front.sv
// ----------------------------------------------------------------------------
// cbm_front
// accepts input transfers and decodes them into mapper commands
// ----------------------------------------------------------------------------
module cbm_front
    import cbm_pkg::*;
(
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  cbm_qstat_t  q_stat,
    output logic        push,
    output cbm_cmd_t    push_cmd
);

    logic [15:0] addr;
    logic [7:0]  data;

    assign addr = s_axis_tdata[15:0];
    assign data = s_axis_tdata[23:16];

    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && !q_stat.full;

    always_comb begin
        push_cmd.op  = OP_NOP;
        push_cmd.arg = data;
        unique case (cbm_req_t'(s_axis_tuser))
            REQ_LOW: begin
                unique case (addr)
                    ADDR_SCREEN: begin
                        push_cmd.op  = OP_MIRROR;
                        push_cmd.arg = {4'd0, data[4] ? MAP_SINGLE1 : MAP_SINGLE0};
                    end
                    ADDR_MIRROR: begin
                        push_cmd.op  = OP_MIRROR;
                        push_cmd.arg = {4'd0, data[4] ? MAP_HORIZ : MAP_VERT};
                    end
                    ADDR_IRQ_OFF: push_cmd.op = OP_IRQ_OFF;
                    ADDR_CNT_LO:  push_cmd.op = OP_CNT_LO;
                    ADDR_CNT_HI:  push_cmd.op = OP_CNT_HI;
                    default:      push_cmd.op = OP_NOP;
                endcase
            end
            REQ_ROM:  push_cmd.op = OP_ROM;
            REQ_TICK: push_cmd.op = OP_TICK;
            default:  push_cmd.op = OP_NOP;
        endcase
    end

endmodule

FILE: hdl/cbm_queue.sv
// ----------------------------------------------------------------------------
// cbm_queue
// short command fifo between decode and execute
// ----------------------------------------------------------------------------
module cbm_queue
    import cbm_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cbm_cmd_t   push_cmd,
    input  logic       pop,
    output cbm_cmd_t   pop_cmd,
    output cbm_qstat_t q_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cbm_cmd_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/cbm_back.sv
// ----------------------------------------------------------------------------
// cbm_back
// executes commands on the mapper state and registers the result
// ----------------------------------------------------------------------------
module cbm_back
    import cbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cbm_cmd_t    cmd,
    input  cbm_qstat_t  q_stat,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata
);

    logic [3:0]  prg_reg, prg_next;
    logic [1:0]  chr_reg, chr_next;
    logic [3:0]  map_reg, map_next;
    logic        armed_reg, armed_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        pulse;
    logic [16:0] sum;
    logic        out_valid_reg;
    cbm_result_t out_data_reg, out_data_next;

    // take a command whenever the output slot is free or being drained
    assign pop = !q_stat.empty && (!out_valid_reg || m_axis_tready);
    assign sum = {1'b0, cnt_reg} + TICK_STEP;

    always_comb begin
        prg_next   = prg_reg;
        chr_next   = chr_reg;
        map_next   = map_reg;
        armed_next = armed_reg;
        cnt_next   = cnt_reg;
        pulse      = 1'b0;
        unique case (cmd.op)
            OP_MIRROR:  map_next = cmd.arg[3:0];
            OP_IRQ_OFF: armed_next = 1'b0;
            OP_CNT_LO:  cnt_next = {cnt_reg[15:8], cmd.arg};
            OP_CNT_HI: begin
                cnt_next   = {cmd.arg, cnt_reg[7:0]};
                armed_next = 1'b1;
            end
            OP_ROM: begin
                prg_next = cmd.arg[5:2];
                chr_next = cmd.arg[1:0];
            end
            OP_TICK: begin
                if (armed_reg) begin
                    if (sum >= CNT_LIMIT) begin
                        pulse    = 1'b1;
                        cnt_next = '0;
                    end else begin
                        cnt_next = sum[15:0];
                    end
                end
            end
            default: ;
        endcase

        out_data_next.pad       = '0;
        out_data_next.irq_count = cnt_next;
        out_data_next.irq_armed = armed_next;
        out_data_next.irq_pulse = pulse;
        out_data_next.nt_map    = map_next;
        out_data_next.chr_page  = chr_next;
        out_data_next.prg_page  = prg_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_reg       <= '0;
            chr_reg       <= '0;
            map_reg       <= MAP_VERT;
            armed_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                prg_reg   <= prg_next;
                chr_reg   <= chr_next;
                map_reg   <= map_next;
                armed_reg <= armed_next;
                cnt_reg   <= cnt_next;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the cartridge bank mapper: a directed table of
// register writes, rom writes and scanline ticks, then random request
// sequences; every result transfer is compared with the state typed into its
// table row, else with an in-bench shadow of the mapper state, under random
// idling on both channels and one long result hold-off that backs requests up
// ----------------------------------------------------------------------------
module tb_top;
    import cbm_pkg::*;

    localparam int RANDOM_ITEMS = 1425;  // random requests after the table
    localparam int QUIET_ITEMS  = 150;   // closing stretch with no idling
    localparam int HOLD_AT      = 500;   // request count that starts the hold-off
    localparam int HOLD_CYCLES  = 64;    // length of the long result hold-off
    localparam int IDLE_LIMIT   = 2000;  // cycles without any transfer
    localparam int DRAIN_CYCLES = 8;     // settle time after the last result

    // fixed expectation carried next to a table row
    typedef struct packed {
        logic        fixed;
        cbm_result_t value;
    } known_t;

    typedef struct packed {
        cbm_req_t    kind;
        logic [15:0] addr;
        logic [7:0]  data;
        known_t      known;
    } stim_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // [15:0] addr, [23:16] data
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [3:0] prg, [5:4] chr, [9:6] nt_map, [10] pulse,
                                       // [11] armed, [27:12] count, [31:28] zero

    // shadow copy of the mapper state
    logic [3:0]  shadow_prg   = '0;
    logic [1:0]  shadow_chr   = '0;
    logic [3:0]  shadow_map   = MAP_VERT;
    logic        shadow_armed = 1'b0;
    logic [15:0] shadow_count = '0;

    stim_row_t   directed_rows[$];
    known_t      known_queue[$];       // one entry per offered request, in order
    cbm_result_t expected_states[$];   // mapper states still owed by the block

    int n_errors    = 0;
    int n_accepted  = 0;
    int n_ticks     = 0;
    int n_overflows = 0;
    int n_backpress = 0;               // cycles the request channel was stalled
    bit quiet       = 1'b0;            // no idling on either side
    bit hold_active = 1'b0;            // long hold-off running on the result side

    cartridge_bank_mapper_with_irq_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // advance the shadow state by one request and return the state it shows
    function automatic cbm_result_t predict_mapper(cbm_req_t kind, logic [15:0] addr,
                                                   logic [7:0] data);
        cbm_result_t r;
        logic [16:0] sum;
        logic        pulse;
        pulse = 1'b0;
        case (kind)
            REQ_LOW: begin
                case (addr)
                    ADDR_SCREEN: shadow_map = data[4] ? MAP_SINGLE1 : MAP_SINGLE0;
                    ADDR_MIRROR: shadow_map = data[4] ? MAP_HORIZ : MAP_VERT;
                    ADDR_IRQ_OFF: shadow_armed = 1'b0;
                    ADDR_CNT_LO: shadow_count[7:0] = data;
                    ADDR_CNT_HI: begin
                        shadow_count[15:8] = data;
                        shadow_armed       = 1'b1;
                    end
                    default: ;
                endcase
            end
            REQ_ROM: begin
                shadow_prg = data[5:2];
                shadow_chr = data[1:0];
            end
            REQ_TICK: begin
                if (shadow_armed) begin
                    sum = {1'b0, shadow_count} + TICK_STEP;
                    // reaching the limit exactly also overflows
                    if (sum >= CNT_LIMIT) begin
                        pulse = 1'b1;
                        sum   = '0;
                    end
                    shadow_count = sum[15:0];
                end
            end
            default: ;
        endcase
        r           = '0;
        r.prg_page  = shadow_prg;
        r.chr_page  = shadow_chr;
        r.nt_map    = shadow_map;
        r.irq_pulse = pulse;
        r.irq_armed = shadow_armed;
        r.irq_count = shadow_count;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // table row; the state after it is typed in only when fixed is set
    task automatic add_row(cbm_req_t kind, logic [15:0] addr, logic [7:0] data,
                           logic fixed, logic [3:0] prg, logic [1:0] chr,
                           logic [3:0] nt, logic pulse, logic armed, logic [15:0] cnt);
        stim_row_t row;
        row.kind                  = kind;
        row.addr                  = addr;
        row.data                  = data;
        row.known.fixed           = fixed;
        row.known.value           = '0;
        row.known.value.prg_page  = prg;
        row.known.value.chr_page  = chr;
        row.known.value.nt_map    = nt;
        row.known.value.irq_pulse = pulse;
        row.known.value.irq_armed = armed;
        row.known.value.irq_count = cnt;
        directed_rows.push_back(row);
    endtask

    // offer one request and hold it until the transfer happens
    task automatic send_request(stim_row_t row);
        if (!quiet && !hold_active && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        known_queue.push_back(row.known);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.kind;
        s_axis_tdata  <= {row.data, row.addr};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // random request, mostly well-formed counter and bank traffic
    function automatic stim_row_t random_request();
        stim_row_t   row;
        int unsigned pick;
        row.known = '0;
        row.kind  = REQ_LOW;
        row.addr  = 16'($urandom);
        row.data  = 8'($urandom);
        pick      = $urandom_range(0, 99);
        if (pick < 35) begin
            row.kind = REQ_TICK;
        end else if (pick < 50) begin
            row.kind = REQ_ROM;
        end else if (pick < 58) begin
            row.addr = $urandom_range(0, 1) ? ADDR_SCREEN : ADDR_MIRROR;
        end else if (pick < 66) begin
            row.addr = ADDR_CNT_LO;
        end else if (pick < 76) begin
            // high bytes near the top keep overflows frequent
            row.addr = ADDR_CNT_HI;
            if ($urandom_range(0, 9) < 6)
                row.data = 8'($urandom_range(8'hF8, 8'hFF));
        end else if (pick < 80) begin
            row.addr = ADDR_IRQ_OFF;
        end else if (pick < 90) begin
            // low writes around the decoded addresses, mostly ignored
            if ($urandom_range(0, 1))
                row.addr = 16'($urandom_range(16'h42F0, 16'h450F));
        end else if (pick < 95) begin
            row.kind = REQ_RSVD;
        end else begin
            row.kind = cbm_req_t'($urandom_range(0, 3));
        end
        return row;
    endfunction

    // transfer monitor: predict on request transfers, compare on result transfers
    always @(posedge aclk) begin : monitor
        known_t      k;
        cbm_result_t pred;
        cbm_result_t want;
        cbm_result_t got;
        if (aresetn) begin
            if (s_axis_tvalid && !s_axis_tready)
                n_backpress++;
            if (s_axis_tvalid && s_axis_tready) begin
                k    = known_queue.pop_front();
                pred = predict_mapper(cbm_req_t'(s_axis_tuser), s_axis_tdata[15:0],
                                      s_axis_tdata[23:16]);
                expected_states.push_back(k.fixed ? k.value : pred);
                n_accepted++;
                if (s_axis_tuser == REQ_TICK)
                    n_ticks++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (got.irq_pulse)
                    n_overflows++;
                if (expected_states.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_axis_tdata);
                    n_errors++;
                end else begin
                    want = expected_states.pop_front();
                    check_field("prg_page", want.prg_page, got.prg_page);
                    check_field("chr_page", want.chr_page, got.chr_page);
                    check_field("nt_map", want.nt_map, got.nt_map);
                    check_field("irq_pulse", want.irq_pulse, got.irq_pulse);
                    check_field("irq_armed", want.irq_armed, got.irq_armed);
                    check_field("irq_count", want.irq_count, got.irq_count);
                end
            end
        end
    end

    // result side: random stall bursts and one long hold-off
    initial begin : receiver
        int  stall_left;
        bit  hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && n_accepted >= HOLD_AT) begin
                // sender keeps offering so the queue fills and tready drops
                hold_done     = 1'b1;
                hold_active   = 1'b1;
                stall_left    = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (aresetn && !quiet && $urandom_range(0, 5) == 0) begin
                hold_active   = 1'b0;
                stall_left    = $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end else begin
                hold_active   = 1'b0;
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ends the run when no transfer happens for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $error("no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin : stimulus
        stim_row_t row;

        // state right after reset, ignored kinds and mirroring
        add_row(REQ_TICK, 16'h0000, 8'h00, 1, 4'd0, 2'd0, MAP_VERT, 0, 0, 16'h0000);
        add_row(REQ_RSVD, 16'hFFFF, 8'hFF, 1, 4'd0, 2'd0, MAP_VERT, 0, 0, 16'h0000);
        add_row(REQ_LOW, ADDR_SCREEN, 8'h10, 1, 4'd0, 2'd0, MAP_SINGLE1, 0, 0, 16'h0000);
        add_row(REQ_LOW, ADDR_SCREEN, 8'hEF, 1, 4'd0, 2'd0, MAP_SINGLE0, 0, 0, 16'h0000);
        add_row(REQ_LOW, ADDR_MIRROR, 8'hFF, 1, 4'd0, 2'd0, MAP_HORIZ, 0, 0, 16'h0000);
        add_row(REQ_LOW, ADDR_MIRROR, 8'h00, 1, 4'd0, 2'd0, MAP_VERT, 0, 0, 16'h0000);
        // rom writes at the extremes, address not decoded
        add_row(REQ_ROM, 16'h0000, 8'hFF, 1, 4'd15, 2'd3, MAP_VERT, 0, 0, 16'h0000);
        add_row(REQ_ROM, 16'hFFFF, 8'h00, 1, 4'd0, 2'd0, MAP_VERT, 0, 0, 16'h0000);
        add_row(REQ_ROM, 16'h8000, 8'h5A, 0, '0, '0, '0, 0, 0, '0);
        // low byte load leaves the counter disarmed, tick does nothing
        add_row(REQ_LOW, ADDR_CNT_LO, 8'hFF, 0, '0, '0, '0, 0, 0, '0);
        add_row(REQ_TICK, 16'h1234, 8'hAB, 0, '0, '0, '0, 0, 0, '0);
        // high byte arms at the top, next tick overflows
        add_row(REQ_LOW, ADDR_CNT_HI, 8'hFF, 0, '0, '0, '0, 0, 0, '0);
        add_row(REQ_TICK, 16'h0000, 8'h00, 1, 4'd6, 2'd2, MAP_VERT, 1, 1, 16'h0000);
        // sum landing exactly on the limit
        add_row(REQ_LOW, ADDR_CNT_LO, 8'h7A, 0, '0, '0, '0, 0, 0, '0);
        add_row(REQ_LOW, ADDR_CNT_HI, 8'hFF, 0, '0, '0, '0, 0, 0, '0);
        add_row(REQ_TICK, 16'h0000, 8'h00, 1, 4'd6, 2'd2, MAP_VERT, 1, 1, 16'h0000);
        // one below the limit, then overflow on the following tick
        add_row(REQ_LOW, ADDR_CNT_LO, 8'h79, 0, '0, '0, '0, 0, 0, '0);
        add_row(REQ_LOW, ADDR_CNT_HI, 8'hFF, 0, '0, '0, '0, 0, 0, '0);
        add_row(REQ_TICK, 16'h0000, 8'h00, 0, '0, '0, '0, 0, 0, '0);
        add_row(REQ_TICK, 16'hFFFF, 8'hFF, 0, '0, '0, '0, 0, 0, '0);
        // disarm, then a tick while disarmed
        add_row(REQ_LOW, ADDR_IRQ_OFF, 8'h00, 0, '0, '0, '0, 0, 0, '0);
        add_row(REQ_TICK, 16'h0000, 8'h00, 0, '0, '0, '0, 0, 0, '0);
        // undecoded low addresses
        add_row(REQ_LOW, 16'h4500, 8'hFF, 0, '0, '0, '0, 0, 0, '0);
        add_row(REQ_LOW, 16'h0000, 8'h00, 0, '0, '0, '0, 0, 0, '0);
        add_row(REQ_LOW, 16'hFFFF, 8'hFF, 0, '0, '0, '0, 0, 0, '0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i]);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            row = random_request();
            send_request(row);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_states.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests: %0d scanline ticks, %0d irq overflows",
                 n_accepted, n_ticks, n_overflows);
        $display("random idling on both channels, request side stalled for %0d cycles",
                 n_backpress);
        if (n_errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: cartridge_bank_mapper_with_irq_top.f
+incdir+hdl
hdl/cbm_pkg.sv
hdl/cbm_front.sv
hdl/cbm_queue.sv
hdl/cbm_back.sv
hdl/cartridge_bank_mapper_with_irq_top.sv
sim/tb_top.sv
